FILE: rtl/mfw_pkg.sv
// Package for the mutex bank with FIFO waiters: sizes, field widths, status codes
// and the types shared between the lock table, the wait store and the top level.
// No dependencies.
package mfw_pkg;

   // Bank size and per-lock queue depth.
   localparam int NUM_LOCKS   = 3;
   localparam int QUEUE_DEPTH = 16;

   // Field widths on the ports.
   localparam int LOCK_W   = 3;
   localparam int PID_W    = 8;
   localparam int STATUS_W = 3;

   // Internal widths derived from the bank size and queue depth.
   localparam int LOCK_SEL_W = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1;
   localparam int SLOT_W     = $clog2(QUEUE_DEPTH);
   localparam int COUNT_W    = $clog2(QUEUE_DEPTH + 1);

   // Request modes.
   localparam logic MODE_ACQUIRE = 1'b0;
   localparam logic MODE_RELEASE = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_ACQUIRED   = 3'd0,
      STATUS_BLOCKED    = 3'd1,
      STATUS_FREED      = 3'd2,
      STATUS_HANDED     = 3'd3,
      STATUS_UNKNOWN    = 3'd4,
      STATUS_NOT_OWNER  = 3'd5,
      STATUS_QUEUE_FULL = 3'd6
   } status_type;

   typedef logic [LOCK_SEL_W-1:0] lock_sel_type;
   typedef logic [SLOT_W-1:0]     slot_type;
   typedef logic [COUNT_W-1:0]    count_type;
   typedef logic [PID_W-1:0]      pid_type;

   // One request as held in the input register.
   typedef struct packed {
      logic              mode;
      logic [LOCK_W-1:0] lock_index;
      pid_type           pid;
   } request_type;

   // Write into the wait store: one slot of one lock's queue.
   typedef struct packed {
      logic         en;
      lock_sel_type lock;
      slot_type     slot;
      pid_type      data;
   } qwrite_type;

   // Read of the wait store: the head slot of the lock that the next request names.
   typedef struct packed {
      logic         en;
      lock_sel_type lock;
      slot_type     slot;
   } qread_type;

endpackage

FILE: rtl/mfw_wait_store.sv
// Wait store: the queue slots of all locks, one write port and one registered read port.
// Depends on mfw_pkg.
module mfw_wait_store (
   input  logic                clock,
   input  mfw_pkg::qwrite_type wr,
   input  mfw_pkg::qread_type  rd,
   output mfw_pkg::pid_type    rd_data
);
   import mfw_pkg::*;

   pid_type mem [NUM_LOCKS][QUEUE_DEPTH];
   pid_type rd_data_ff;

   // Write the pushed id into its slot.
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.lock][wr.slot] <= wr.data;
      end
   end

   // Registered read; a write to the same slot in the same cycle is passed through.
   always_ff @(posedge clock) begin
      if (rd.en) begin
         if (wr.en && (wr.lock == rd.lock) && (wr.slot == rd.slot)) begin
            rd_data_ff <= wr.data;
         end else begin
            rd_data_ff <= mem[rd.lock][rd.slot];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/mfw_lock_table.sv
// Lock table: held flag, owner, queue head and queue count of every lock, and the
// decision for the request in the input register. Depends on mfw_pkg.
module mfw_lock_table (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  mfw_pkg::request_type       cur,
   input  mfw_pkg::pid_type           head_pid,
   input  logic                       next_take,
   input  logic [mfw_pkg::LOCK_W-1:0] next_lock_index,
   output mfw_pkg::qwrite_type        wr,
   output mfw_pkg::qread_type         rd,
   output mfw_pkg::status_type        status,
   output mfw_pkg::pid_type           next_owner
);
   import mfw_pkg::*;

   logic      held_ff  [NUM_LOCKS];
   pid_type   owner_ff [NUM_LOCKS];
   slot_type  head_ff  [NUM_LOCKS];
   count_type count_ff [NUM_LOCKS];

   logic      held_in  [NUM_LOCKS];
   pid_type   owner_in [NUM_LOCKS];
   slot_type  head_in  [NUM_LOCKS];
   count_type count_in [NUM_LOCKS];

   logic         cur_known;
   lock_sel_type cur_sel;
   logic         next_known;
   lock_sel_type next_sel;

   assign cur_known  = {1'b0, cur.lock_index} < (LOCK_W + 1)'(NUM_LOCKS);
   assign cur_sel    = cur_known ? cur.lock_index[LOCK_SEL_W-1:0] : '0;
   assign next_known = {1'b0, next_lock_index} < (LOCK_W + 1)'(NUM_LOCKS);
   assign next_sel   = next_known ? next_lock_index[LOCK_SEL_W-1:0] : '0;

   // Decide the outcome for the current request and form the next state of its lock.
   always_comb begin
      logic                 sel_held;
      pid_type              sel_owner;
      slot_type             sel_head;
      count_type            sel_count;
      logic                 held_nx;
      pid_type              owner_nx;
      slot_type             head_nx;
      count_type            count_nx;
      logic [SLOT_W:0]      tail_sum;
      slot_type             tail_slot;
      logic                 push;

      sel_held  = 1'b0;
      sel_owner = '0;
      sel_head  = '0;
      sel_count = '0;
      for (int i = 0; i < NUM_LOCKS; i++) begin
         if (cur_sel == LOCK_SEL_W'(i)) begin
            sel_held  = held_ff[i];
            sel_owner = owner_ff[i];
            sel_head  = head_ff[i];
            sel_count = count_ff[i];
         end
      end

      tail_sum = {1'b0, sel_head} + {1'b0, sel_count[SLOT_W-1:0]};
      if (tail_sum >= (SLOT_W + 1)'(QUEUE_DEPTH)) begin
         tail_sum = tail_sum - (SLOT_W + 1)'(QUEUE_DEPTH);
      end
      tail_slot = tail_sum[SLOT_W-1:0];

      held_nx    = sel_held;
      owner_nx   = sel_owner;
      head_nx    = sel_head;
      count_nx   = sel_count;
      push       = 1'b0;
      status     = STATUS_UNKNOWN;
      next_owner = '0;

      if (cur_known) begin
         if (cur.mode == MODE_ACQUIRE) begin
            if (!sel_held) begin
               held_nx  = 1'b1;
               owner_nx = cur.pid;
               status   = STATUS_ACQUIRED;
            end else if (sel_count == COUNT_W'(QUEUE_DEPTH)) begin
               status = STATUS_QUEUE_FULL;
            end else begin
               push     = 1'b1;
               count_nx = sel_count + 1'b1;
               status   = STATUS_BLOCKED;
            end
         end else begin
            if (!sel_held || (sel_owner != cur.pid)) begin
               status = STATUS_NOT_OWNER;
            end else if (sel_count != '0) begin
               next_owner = head_pid;
               owner_nx   = head_pid;
               head_nx    = (sel_head == SLOT_W'(QUEUE_DEPTH - 1)) ? '0 : sel_head + 1'b1;
               count_nx   = sel_count - 1'b1;
               status     = STATUS_HANDED;
            end else begin
               held_nx  = 1'b0;
               owner_nx = '0;
               status   = STATUS_FREED;
            end
         end
      end

      for (int i = 0; i < NUM_LOCKS; i++) begin
         if (cur_known && (cur_sel == LOCK_SEL_W'(i))) begin
            held_in[i]  = held_nx;
            owner_in[i] = owner_nx;
            head_in[i]  = head_nx;
            count_in[i] = count_nx;
         end else begin
            held_in[i]  = held_ff[i];
            owner_in[i] = owner_ff[i];
            head_in[i]  = head_ff[i];
            count_in[i] = count_ff[i];
         end
      end

      wr.en   = advance && push;
      wr.lock = cur_sel;
      wr.slot = tail_slot;
      wr.data = cur.pid;
   end

   // Head slot for the request being taken now, as its lock stands after this cycle.
   always_comb begin
      rd.en   = next_take;
      rd.lock = next_sel;
      rd.slot = '0;
      for (int i = 0; i < NUM_LOCKS; i++) begin
         if (next_sel == LOCK_SEL_W'(i)) begin
            rd.slot = advance ? head_in[i] : head_ff[i];
         end
      end
   end

   // Lock state commits when the request moves on to the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_LOCKS; i++) begin
            held_ff[i]  <= 1'b0;
            owner_ff[i] <= '0;
            head_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
      end else if (advance) begin
         for (int i = 0; i < NUM_LOCKS; i++) begin
            held_ff[i]  <= held_in[i];
            owner_ff[i] <= owner_in[i];
            head_ff[i]  <= head_in[i];
            count_ff[i] <= count_in[i];
         end
      end
   end

endmodule

FILE: rtl/mutex_unit_with_fifo_waiters.sv
// Top level of the mutex bank with FIFO waiters: input register, result register,
// lock table and wait store. Depends on mfw_pkg, mfw_lock_table and mfw_wait_store.
//
//   Channel   Direction   Ports                                            Flow control
//   req       in          req_mode, req_lock_index, req_process_id         req_valid / req_stall
//   rsp       out         rsp_status, rsp_next_owner                       rsp_valid / rsp_stall
//
// One request is taken per cycle while req_stall is low, and each gives exactly one result beat.
// A request beat is loaded into the input register (with the wait store head read) when it is
// accepted, and into the result register when it moves on; its result beat is shown from there.
// Reset is synchronous and frees every lock with an empty queue; no clearing pass.
// A stall on rsp holds the result register and, when the input register is full,
// raises req_stall in the same cycle.
module mutex_unit_with_fifo_waiters (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_mode,
   input  logic [mfw_pkg::LOCK_W-1:0]   req_lock_index,
   input  logic [mfw_pkg::PID_W-1:0]    req_process_id,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [mfw_pkg::STATUS_W-1:0] rsp_status,
   output logic [mfw_pkg::PID_W-1:0]    rsp_next_owner
);
   import mfw_pkg::*;

   logic        req_valid_ff;
   logic        req_valid_in;
   request_type req_ff;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   status_type  rsp_status_ff;
   pid_type     rsp_next_owner_ff;

   logic       advance;
   logic       take;
   qwrite_type wr;
   qread_type  rd;
   pid_type    head_pid;
   status_type lt_status;
   pid_type    lt_next_owner;

   // The held request moves on when the result register is free or being emptied.
   assign advance      = req_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall    = req_valid_ff && !advance;
   assign take         = req_valid && !req_stall;
   assign req_valid_in = take || (req_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
      end
      if (take) begin
         req_ff.mode       <= req_mode;
         req_ff.lock_index <= req_lock_index;
         req_ff.pid        <= req_process_id;
      end
   end

   mfw_lock_table u_lock_table (
      .clock           (clock),
      .reset           (reset),
      .advance         (advance),
      .cur             (req_ff),
      .head_pid        (head_pid),
      .next_take       (take),
      .next_lock_index (req_lock_index),
      .wr              (wr),
      .rd              (rd),
      .status          (lt_status),
      .next_owner      (lt_next_owner)
   );

   mfw_wait_store u_wait_store (
      .clock   (clock),
      .wr      (wr),
      .rd      (rd),
      .rd_data (head_pid)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (advance) begin
         rsp_status_ff     <= lt_status;
         rsp_next_owner_ff <= lt_next_owner;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_next_owner = rsp_next_owner_ff;

   // A request that moves on always shows up as a result beat.
   a_advance_gives_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("request moved on without a result beat");

   // The next owner field is zero unless the lock was handed over.
   a_next_owner_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != STATUS_HANDED)) |-> (rsp_next_owner == '0))
      else $error("next owner set on a result that is not a hand-over");

   // The wait store is written only for a request that ends up blocked.
   a_push_only_blocked: assert property (@(posedge clock) disable iff (reset)
      wr.en |-> (advance && (lt_status == STATUS_BLOCKED)))
      else $error("queue write without a blocked request");

   // A stalled result beat holds its fields.
   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> ($stable(rsp_status) && $stable(rsp_next_owner)))
      else $error("result changed while stalled");

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for mutex_unit_with_fifo_waiters: a directed table followed by
// random lock traffic, each result beat checked against its literal row or an in-bench lock bank predictor.
// Depends on mfw_pkg and the mutex_unit_with_fifo_waiters RTL.
module tb_top;
   import mfw_pkg::*;

   // Longest stretch with no beat on either channel before the run is abandoned.
   localparam int QUIET_LIMIT = 2000;
   localparam int SEGMENTS    = 7;
   localparam int SEG_ITEMS   = 200;
   localparam int N_ROWS      = 21;

   typedef struct packed {
      status_type status;
      pid_type    next_owner;
   } outcome_type;

   typedef struct {
      logic              mode;
      logic [LOCK_W-1:0] lock;
      pid_type           pid;
      int                reps;
      bit                literal;
      status_type        lit_status;
      pid_type           lit_next;
   } stim_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic              req_mode = MODE_ACQUIRE;
   logic [LOCK_W-1:0] req_lock_index = '0;
   pid_type           req_process_id = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   pid_type           rsp_next_owner;

   // Predictor state: one owner and one ring of waiters per lock.
   bit      lock_held [NUM_LOCKS];
   pid_type lock_owner [NUM_LOCKS];
   pid_type waiter_ring [NUM_LOCKS][QUEUE_DEPTH];
   int      ring_first [NUM_LOCKS];
   int      ring_fill [NUM_LOCKS];

   outcome_type expected_outcomes [$];
   outcome_type oldest_outcome;

   bit          idle_on = 1'b1;
   int unsigned hold_draw;
   int unsigned hold_left = 0;
   int          quiet_cycles = 0;
   int          fail_count = 0;
   int          requests_sent = 0;
   int          results_checked = 0;
   int          handovers = 0;
   int          overflows = 0;

   // Directed rows; a row with literal set carries its own expected beat.
   stim_row_type directed_rows [N_ROWS] = '{
      '{MODE_ACQUIRE, 3'd0, 8'h00, 1, 1'b1, STATUS_ACQUIRED, 8'h00},
      '{MODE_ACQUIRE, 3'd0, 8'hFF, 1, 1'b1, STATUS_BLOCKED, 8'h00},
      '{MODE_ACQUIRE, 3'd0, 8'h00, 1, 1'b1, STATUS_BLOCKED, 8'h00},
      '{MODE_RELEASE, 3'd0, 8'h55, 1, 1'b1, STATUS_NOT_OWNER, 8'h00},
      '{MODE_RELEASE, 3'd0, 8'h00, 1, 1'b1, STATUS_HANDED, 8'hFF},
      '{MODE_RELEASE, 3'd0, 8'hFF, 1, 1'b1, STATUS_HANDED, 8'h00},
      '{MODE_RELEASE, 3'd0, 8'h00, 1, 1'b1, STATUS_FREED, 8'h00},
      '{MODE_RELEASE, 3'd0, 8'h00, 1, 1'b1, STATUS_NOT_OWNER, 8'h00},
      '{MODE_ACQUIRE, 3'd3, 8'h12, 1, 1'b1, STATUS_UNKNOWN, 8'h00},
      '{MODE_RELEASE, 3'd7, 8'hFF, 1, 1'b1, STATUS_UNKNOWN, 8'h00},
      '{MODE_ACQUIRE, 3'd1, 8'h01, 1, 1'b1, STATUS_ACQUIRED, 8'h00},
      '{MODE_RELEASE, 3'd1, 8'h02, 1, 1'b1, STATUS_NOT_OWNER, 8'h00},
      '{MODE_ACQUIRE, 3'd2, 8'hAA, 1, 1'b1, STATUS_ACQUIRED, 8'h00},
      '{MODE_ACQUIRE, 3'd2, 8'h10, QUEUE_DEPTH, 1'b1, STATUS_BLOCKED, 8'h00},
      '{MODE_ACQUIRE, 3'd2, 8'h77, 1, 1'b1, STATUS_QUEUE_FULL, 8'h00},
      '{MODE_RELEASE, 3'd2, 8'hAA, 1, 1'b1, STATUS_HANDED, 8'h10},
      '{MODE_ACQUIRE, 3'd2, 8'hE0, 1, 1'b0, STATUS_ACQUIRED, 8'h00},
      '{MODE_RELEASE, 3'd2, 8'h10, QUEUE_DEPTH, 1'b0, STATUS_ACQUIRED, 8'h00},
      '{MODE_RELEASE, 3'd2, 8'hE0, 1, 1'b0, STATUS_ACQUIRED, 8'h00},
      '{MODE_RELEASE, 3'd1, 8'h01, 1, 1'b1, STATUS_FREED, 8'h00},
      '{MODE_ACQUIRE, 3'd5, 8'h80, 1, 1'b1, STATUS_UNKNOWN, 8'h00}
   };

   mutex_unit_with_fifo_waiters dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_mode       (req_mode),
      .req_lock_index (req_lock_index),
      .req_process_id (req_process_id),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_next_owner (rsp_next_owner)
   );

   // Free-running clock with a period of ten units.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Applies one request to the predicted lock bank and returns the beat it should yield.
   function automatic outcome_type resolve_lock_request(input logic mode,
                                                        input logic [LOCK_W-1:0] idx,
                                                        input pid_type pid);
      outcome_type res;
      int          k;
      res.status = STATUS_ACQUIRED;
      res.next_owner = '0;
      k = int'(idx);
      if (k >= NUM_LOCKS) begin
         res.status = STATUS_UNKNOWN;
      end else if (mode == MODE_ACQUIRE) begin
         if (!lock_held[k]) begin
            lock_held[k] = 1'b1;
            lock_owner[k] = pid;
            res.status = STATUS_ACQUIRED;
         end else if (ring_fill[k] >= QUEUE_DEPTH) begin
            res.status = STATUS_QUEUE_FULL;
         end else begin
            waiter_ring[k][(ring_first[k] + ring_fill[k]) % QUEUE_DEPTH] = pid;
            ring_fill[k]++;
            res.status = STATUS_BLOCKED;
         end
      end else if (!lock_held[k] || lock_owner[k] != pid) begin
         res.status = STATUS_NOT_OWNER;
      end else if (ring_fill[k] != 0) begin
         // The oldest waiter takes the lock over.
         res.next_owner = waiter_ring[k][ring_first[k]];
         ring_first[k] = (ring_first[k] + 1) % QUEUE_DEPTH;
         ring_fill[k]--;
         lock_owner[k] = res.next_owner;
         res.status = STATUS_HANDED;
      end else begin
         lock_held[k] = 1'b0;
         lock_owner[k] = '0;
         res.status = STATUS_FREED;
      end
      return res;
   endfunction

   // Presents one request beat, after a random gap while idle_on is set, and records its expected result.
   task automatic send_request(input logic mode, input logic [LOCK_W-1:0] idx,
                               input pid_type pid, input bit literal,
                               input status_type lit_status, input pid_type lit_next);
      int unsigned gap;
      outcome_type predicted;
      gap = idle_on ? $urandom_range(0, 3) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_lock_index <= idx;
      req_process_id <= pid;
      do @(posedge clock); while (req_stall);
      predicted = resolve_lock_request(mode, idx, pid);
      if (literal) begin
         predicted.status = lit_status;
         predicted.next_owner = lit_next;
      end
      if (predicted.status == STATUS_HANDED) handovers++;
      if (predicted.status == STATUS_QUEUE_FULL) overflows++;
      expected_outcomes.push_back(predicted);
      requests_sent++;
   endtask

   // Drops valid and holds off until every outstanding result beat has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_outcomes.size() != 0);
   endtask

   // Random traffic: mostly real lock sequences, where releases usually come from the owner.
   task automatic random_request(input int acquire_pct);
      logic [LOCK_W-1:0] idx;
      logic              mode;
      pid_type           pid;
      mode = 1'($urandom_range(0, 1));
      pid = pid_type'($urandom_range(0, 255));
      if ($urandom_range(0, 99) < 5 && NUM_LOCKS < 2**LOCK_W) begin
         idx = LOCK_W'($urandom_range(NUM_LOCKS, 2**LOCK_W - 1));
      end else begin
         idx = LOCK_W'($urandom_range(0, NUM_LOCKS - 1));
         mode = ($urandom_range(0, 99) < acquire_pct) ? MODE_ACQUIRE : MODE_RELEASE;
         if (mode == MODE_RELEASE && lock_held[idx] && $urandom_range(0, 99) < 85)
            pid = lock_owner[idx];
      end
      send_request(mode, idx, pid, 1'b0, STATUS_ACQUIRED, 8'h00);
   endtask

   // Result side: after each accepted beat, draw a random stall while idle_on is set.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
      end else if (rsp_valid && !rsp_stall) begin
         hold_draw = idle_on ? $urandom_range(0, 3) : 0;
         hold_left <= hold_draw;
         rsp_stall <= (hold_draw != 0);
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= (hold_left > 1);
      end
   end

   // Compare every accepted result beat with the oldest outstanding expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_outcomes.size() == 0) begin
            $error("result beat with nothing outstanding: status %0d next_owner 0x%02h",
                   rsp_status, rsp_next_owner);
            fail_count++;
         end else begin
            oldest_outcome = expected_outcomes.pop_front();
            results_checked++;
            if (rsp_status !== oldest_outcome.status) begin
               $error("status: expected %0d, actual %0d", oldest_outcome.status, rsp_status);
               fail_count++;
            end
            if (rsp_next_owner !== oldest_outcome.next_owner) begin
               $error("next_owner: expected 0x%02h, actual 0x%02h",
                      oldest_outcome.next_owner, rsp_next_owner);
               fail_count++;
            end
         end
      end
   end

   // Watchdog: give up when neither channel moves a beat for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout after %0d idle cycles", quiet_cycles);
         $display("mutex_unit_with_fifo_waiters: mismatch");
         $finish;
      end
   end

   // Main sequence: reset, directed table, random segments, final drain.
   initial begin
      for (int i = 0; i < NUM_LOCKS; i++) begin
         lock_held[i] = 1'b0;
         lock_owner[i] = '0;
         ring_first[i] = 0;
         ring_fill[i] = 0;
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed rows; a repeated row steps the process id by one each time.
      foreach (directed_rows[r]) begin
         for (int k = 0; k < directed_rows[r].reps; k++)
            send_request(directed_rows[r].mode, directed_rows[r].lock,
                         pid_type'(directed_rows[r].pid + k), directed_rows[r].literal,
                         directed_rows[r].lit_status, directed_rows[r].lit_next);
      end
      drain_results();

      // Alternate acquire-heavy and release-heavy segments so queues fill, overflow and empty.
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         idle_on = (seg != 2 && seg != 5);
         for (int n = 0; n < SEG_ITEMS; n++)
            random_request((seg % 2 == 0) ? 70 : 35);
         drain_results();
      end
      idle_on = 1'b1;

      repeat (4) @(posedge clock);
      $display("%0d requests sent and %0d results checked, including %0d hand-overs",
               requests_sent, results_checked, handovers);
      $display("and %0d queue-full drops across %0d locks", overflows, NUM_LOCKS);
      if (fail_count == 0 && expected_outcomes.size() == 0)
         $display("mutex_unit_with_fifo_waiters: match");
      else
         $display("mutex_unit_with_fifo_waiters: mismatch");
      $finish;
   end

endmodule
